### src/tmwc_pkg.sv
// ----------------------------------------------------------------------------
// tmwc_pkg: shared types for the temporal motif window counter
// Request and response structs, operation codes, window slot layout.
// ----------------------------------------------------------------------------
`default_nettype none
package tmwc_pkg;

	localparam int EVENT_KINDS_DEF  = 6;
	localparam int WINDOW_DEPTH_DEF = 1024;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_EVENT = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic [2:0]         event_kind;
		logic signed [31:0] event_time;
		logic [7:0]         count_index;
	} req_t;

	typedef struct packed {
		logic [63:0] count_value;
		logic        overflow_seen;
	} rsp_t;

	typedef struct packed {
		logic [31:0] time_bits;
		logic [2:0]  kind;
	} slot_t;

endpackage
`default_nettype wire

### src/tmwc_ram.sv
// ----------------------------------------------------------------------------
// tmwc_ram: count memory with per-entry valid bits
// One write and one registered read port; clear empties it by resetting the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none
module tmwc_ram #(
	parameter int DEPTH_P = 36,
	parameter int WIDTH_P = 32,
	parameter int AW      = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               clr,
	input  wire logic               we,
	input  wire logic [AW-1:0]      waddr,
	input  wire logic [WIDTH_P-1:0] wdata,
	input  wire logic [AW-1:0]      raddr,
	output logic      [WIDTH_P-1:0] rdata
);
	logic [WIDTH_P-1:0] mem [DEPTH_P];
	logic [DEPTH_P-1:0] vld_q;
	logic [WIDTH_P-1:0] rdata_q;
	logic               rvld_q;

	// entries not written since reset or clear read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
		rvld_q  <= vld_q[raddr];
	end

	assign rdata = rvld_q ? rdata_q : '0;
endmodule
`default_nettype wire

### src/tmwc_ring.sv
// ----------------------------------------------------------------------------
// tmwc_ring: window store
// Ring of event slots, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module tmwc_ring
	import tmwc_pkg::*;
#(
	parameter int DEPTH_P = WINDOW_DEPTH_DEF,
	parameter int AW      = $clog2(DEPTH_P)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire slot_t         wdata,
	input  wire logic [AW-1:0] raddr,
	output slot_t              rdata
);
	slot_t mem [DEPTH_P];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### src/temporal_motif_window_counter.sv
// ----------------------------------------------------------------------------
// temporal_motif_window_counter: three-event temporal motif counter
// Sliding-window counting of ordered event triples under a small sequencer.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy low. Start clears all counts
// and the window and never raises busy. A read returns its count on rsp with
// rsp_valid high for one cycle, after states ST_RD_ADDR and ST_RD_DATA; the
// receiver cannot stall it. An event request holds busy while it retires each
// expired window entry, or evicts the oldest on a full store, with K pair
// updates each, then does K*K triple and K pair updates (K = EVENT_KINDS) and
// stores the event: all pair and triple updates go one at a time through the
// single 64-bit adder, each a read then a write of the count memories. An event
// of an unused kind is dropped at once. The user must write window_length
// through cfg_we/cfg_wdata only while idle; the block does not enforce this.
`default_nettype none
module temporal_motif_window_counter
	import tmwc_pkg::*;
#(
	parameter int EVENT_KINDS  = EVENT_KINDS_DEF,
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire req_t        req,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	output logic             rsp_valid,
	output rsp_t             rsp
);
	localparam int K   = EVENT_KINDS;
	localparam int KK  = K * K;
	localparam int KKK = K * K * K;
	localparam int KW  = (K > 1) ? $clog2(K) : 1;
	localparam int PAW = (KK > 1) ? $clog2(KK) : 1;
	localparam int TAW = (KKK > 1) ? $clog2(KKK) : 1;
	localparam int AW  = $clog2(WINDOW_DEPTH);
	localparam int FW  = $clog2(WINDOW_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_EXP_RD, ST_EXP_CHK, ST_RET_PR, ST_RET_PW,
		ST_ADM_RD, ST_ADM_WR, ST_PC_RD, ST_PC_WR, ST_FIN,
		ST_RD_ADDR, ST_RD_DATA
	} state_t;

	state_t             state_q;
	logic [31:0]        wl_q;
	logic [AW-1:0]      head_q;
	logic [FW-1:0]      fill_q;
	logic [FW-1:0]      single_q [K];
	logic               ovf_q;
	logic [KW-1:0]      kind_q;
	logic [31:0]        now_q;
	logic [KW-1:0]      r_q;
	logic [KW-1:0]      i_q;
	logic [PAW-1:0]     pidx_q;
	logic               ovret_q;
	logic [TAW-1:0]     idx_q;
	logic               oor_q;

	logic               accept;
	logic               clr;
	slot_t              st_rd;
	logic [KW-1:0]      st_kind;
	logic               expired;
	logic [AW+1:0]      pos_sum;
	logic [AW-1:0]      wpos;
	logic [AW-1:0]      head_nx;

	logic [PAW-1:0]     p_addr;
	logic               p_we;
	logic [31:0]        p_rd;
	logic [TAW-1:0]     t_raddr;
	logic [TAW-1:0]     t_waddr;
	logic               t_we;
	logic [63:0]        t_rd;

	// the one shared adder
	logic [63:0]        alu_a;
	logic [63:0]        alu_b;
	logic               alu_sub;
	logic [63:0]        alu_y;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign clr    = accept && (req.operation == OP_START);

	assign st_kind = KW'(st_rd.kind);
	// stored + window < now, in 34-bit signed so nothing overflows
	assign expired = (fill_q != '0) &&
		(($signed({{2{st_rd.time_bits[31]}}, st_rd.time_bits}) +
		  $signed({2'b00, wl_q})) < $signed({{2{now_q[31]}}, now_q}));

	assign pos_sum = (AW + 2)'(head_q) + (AW + 2)'(fill_q);
	assign wpos    = (pos_sum >= (AW + 2)'(WINDOW_DEPTH)) ?
		AW'(pos_sum - (AW + 2)'(WINDOW_DEPTH)) : AW'(pos_sum);
	assign head_nx = (head_q == AW'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;

	// memory address steering
	always_comb begin
		p_addr  = '0;
		t_raddr = TAW'(pidx_q * K + kind_q);
		unique case (state_q)
			ST_RET_PR, ST_RET_PW: p_addr = PAW'(r_q * K + i_q);
			ST_ADM_RD, ST_ADM_WR: p_addr = pidx_q;
			ST_PC_RD,  ST_PC_WR:  p_addr = PAW'(i_q * K + kind_q);
			ST_RD_ADDR:           t_raddr = idx_q;
			default: ;
		endcase
	end
	assign t_waddr = TAW'(pidx_q * K + kind_q);
	assign p_we    = (state_q == ST_RET_PW) || (state_q == ST_PC_WR);
	assign t_we    = (state_q == ST_ADM_WR);

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			ST_RET_PW: begin
				alu_a   = 64'(p_rd);
				alu_b   = 64'(single_q[i_q]);
				alu_sub = 1'b1;
			end
			ST_ADM_WR: begin
				alu_a = t_rd;
				alu_b = 64'(p_rd);
			end
			ST_PC_WR: begin
				alu_a = 64'(p_rd);
				alu_b = 64'(single_q[i_q]);
			end
			default: ;
		endcase
	end
	assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

	tmwc_ram #(.DEPTH_P(KK), .WIDTH_P(32), .AW(PAW)) u_pair (
		.clk   (clk),
		.arst_n(arst_n),
		.clr   (clr),
		.we    (p_we),
		.waddr (p_addr),
		.wdata (alu_y[31:0]),
		.raddr (p_addr),
		.rdata (p_rd)
	);

	tmwc_ram #(.DEPTH_P(KKK), .WIDTH_P(64), .AW(TAW)) u_triple (
		.clk   (clk),
		.arst_n(arst_n),
		.clr   (clr),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (alu_y),
		.raddr (t_raddr),
		.rdata (t_rd)
	);

	tmwc_ring #(.DEPTH_P(WINDOW_DEPTH), .AW(AW)) u_ring (
		.clk  (clk),
		.we   (state_q == ST_FIN),
		.waddr(wpos),
		.wdata('{time_bits: now_q, kind: 3'(kind_q)}),
		.raddr(head_q),
		.rdata(st_rd)
	);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= '0;
		end else if (cfg_we) begin
			wl_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			fill_q    <= '0;
			ovf_q     <= 1'b0;
			for (int n = 0; n < K; n++) single_q[n] <= '0;
			rsp_valid <= 1'b0;
			kind_q    <= '0;
			now_q     <= '0;
			r_q       <= '0;
			i_q       <= '0;
			pidx_q    <= '0;
			ovret_q   <= 1'b0;
			idx_q     <= '0;
			oor_q     <= 1'b0;
			rsp       <= '0;
		end else begin
			rsp_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req.operation)
							OP_START: begin
								head_q <= '0;
								fill_q <= '0;
								ovf_q  <= 1'b0;
								for (int n = 0; n < K; n++) single_q[n] <= '0;
							end
							OP_EVENT: begin
								if (32'(req.event_kind) < K) begin
									kind_q  <= KW'(req.event_kind);
									now_q   <= req.event_time;
									state_q <= ST_EXP_RD;
								end
							end
							OP_READ: begin
								idx_q   <= TAW'(req.count_index);
								oor_q   <= (32'(req.count_index) >= KKK);
								state_q <= ST_RD_ADDR;
							end
							default: ;
						endcase
					end
				end
				ST_EXP_RD: state_q <= ST_EXP_CHK;
				ST_EXP_CHK: begin
					i_q <= '0;
					if (expired || (fill_q == FW'(WINDOW_DEPTH))) begin
						single_q[st_kind] <= single_q[st_kind] - 1'b1;
						r_q     <= st_kind;
						ovret_q <= !expired;
						if (!expired) ovf_q <= 1'b1;
						state_q <= ST_RET_PR;
					end else begin
						pidx_q  <= '0;
						state_q <= ST_ADM_RD;
					end
				end
				ST_RET_PR: state_q <= ST_RET_PW;
				ST_RET_PW: begin
					if (i_q == KW'(K - 1)) begin
						head_q  <= head_nx;
						fill_q  <= fill_q - 1'b1;
						pidx_q  <= '0;
						state_q <= ovret_q ? ST_ADM_RD : ST_EXP_RD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_RET_PR;
					end
				end
				ST_ADM_RD: state_q <= ST_ADM_WR;
				ST_ADM_WR: begin
					if (pidx_q == PAW'(KK - 1)) begin
						i_q     <= '0;
						state_q <= ST_PC_RD;
					end else begin
						pidx_q  <= pidx_q + 1'b1;
						state_q <= ST_ADM_RD;
					end
				end
				ST_PC_RD: state_q <= ST_PC_WR;
				ST_PC_WR: begin
					if (i_q == KW'(K - 1)) begin
						state_q <= ST_FIN;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_PC_RD;
					end
				end
				ST_FIN: begin
					single_q[kind_q] <= single_q[kind_q] + 1'b1;
					fill_q  <= fill_q + 1'b1;
					state_q <= ST_IDLE;
				end
				ST_RD_ADDR: state_q <= ST_RD_DATA;
				ST_RD_DATA: begin
					rsp_valid         <= 1'b1;
					rsp.count_value   <= oor_q ? 64'd0 : t_rd;
					rsp.overflow_seen <= ovf_q;
					state_q           <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(WINDOW_DEPTH))
		else $error("window fill beyond depth");

	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.operation == OP_READ) |=> ##2 rsp_valid)
		else $error("read response missing");

	a_bad_kind_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.operation == OP_EVENT && 32'(req.event_kind) >= K) |=> !busy)
		else $error("unused kind not dropped");

endmodule
`default_nettype wire
